/* rtl/emhq_pkg.sv */
// ----------------------------------------------------------------------------
// emhq_pkg: shared types and constants of the event min-heap queue
// Operation kinds, status codes and field widths.
// ----------------------------------------------------------------------------
package emhq_pkg;

    localparam int TAG_W      = 12;
    localparam int TIME_W     = 48;
    localparam int PRIO_W     = 16;
    localparam int COUNT_W    = 13;
    localparam int TAGS       = 4096;
    localparam int CAPACITY_D = 4096;
    localparam int ORDER_D    = 40;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_POP    = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_QUEUED = 3'd3,
        ST_QUEUED    = 3'd4,
        ST_EXHAUSTED = 3'd5
    } status_t;

endpackage

/* rtl/emhq_posmap.sv */
// ----------------------------------------------------------------------------
// emhq_posmap: tag to heap position map
// One write and one registered read per cycle, with a clearing pass that
// walks every tag after reset and on a clear command.
// ----------------------------------------------------------------------------
module emhq_posmap
    import emhq_pkg::*;
#(
    parameter int POS_W = 13
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clear_start,
    output logic             clearing,
    input  logic             wr_en,
    input  logic [TAG_W-1:0] wr_tag,
    input  logic [POS_W-1:0] wr_pos,
    input  logic [TAG_W-1:0] rd_tag,
    output logic [POS_W-1:0] rd_pos
);

    logic [POS_W-1:0] mem [TAGS];
    logic             clearing_reg, clearing_next;
    logic [TAG_W-1:0] clr_idx_reg, clr_idx_next;

    assign clearing = clearing_reg;

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_idx_next  = clr_idx_reg;
        if (clear_start)
        begin
            clearing_next = 1'b1;
            clr_idx_next  = '0;
        end
        else if (clearing_reg)
        begin
            clr_idx_next = clr_idx_reg + 1'b1;
            if (clr_idx_reg == TAG_W'(TAGS - 1))
                clearing_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_idx_reg  <= clr_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
            mem[clr_idx_reg] <= '0;
        else if (wr_en)
            mem[wr_tag] <= wr_pos;
        rd_pos <= mem[rd_tag];
    end

endmodule

/* rtl/emhq_heap_mem.sv */
// ----------------------------------------------------------------------------
// emhq_heap_mem: heap slot storage
// One entry per slot (time, priority, order, tag); one write port and one
// registered read port.
// ----------------------------------------------------------------------------
module emhq_heap_mem
    import emhq_pkg::*;
#(
    parameter int SLOT_W = 13,
    parameter int DEPTH  = 4097,
    parameter int ENT_W  = 116
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [SLOT_W-1:0] wr_addr,
    input  logic [ENT_W-1:0]  wr_data,
    input  logic [SLOT_W-1:0] rd_addr,
    output logic [ENT_W-1:0]  rd_data
);

    logic [ENT_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

endmodule

/* rtl/emhq_before.sv */
// ----------------------------------------------------------------------------
// emhq_before: the shared ordering comparator
// Tells whether entry a is served before entry b: time, then signed
// priority, then insertion order.
// ----------------------------------------------------------------------------
module emhq_before
    import emhq_pkg::*;
#(
    parameter int ORD_W = 40
)
(
    input  logic [TIME_W-1:0]        a_time,
    input  logic signed [PRIO_W-1:0] a_prio,
    input  logic [ORD_W-1:0]         a_ord,
    input  logic [TIME_W-1:0]        b_time,
    input  logic signed [PRIO_W-1:0] b_prio,
    input  logic [ORD_W-1:0]         b_ord,
    output logic                     a_first
);

    always_comb
    begin
        if (a_time != b_time)
            a_first = a_time < b_time;
        else if (a_prio != b_prio)
            a_first = a_prio < b_prio;
        else
            a_first = a_ord < b_ord;
    end

endmodule

/* rtl/event_min_heap_queue_top.sv */
// ----------------------------------------------------------------------------
// event_min_heap_queue_top: binary min-heap event queue
// Insert, pop minimum, remove by tag and clear, one result per command.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its single result
// appears for one cycle with done high and must be captured then. A sequencer
// walks the heap one level at a time through one slot memory and one
// comparator, reading, comparing and writing at each level. After reset and
// after each clear, the tag map is swept one tag per cycle with busy high.
module event_min_heap_queue_top
    import emhq_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_D,
    parameter int ORDER_BITS = ORDER_D
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               kind,
    input  logic [TAG_W-1:0]         event_tag,
    input  logic [TIME_W-1:0]        arrival_time,
    input  logic signed [PRIO_W-1:0] priority_req,
    output logic                     done,
    output logic [2:0]               status,
    output logic [TAG_W-1:0]         out_tag,
    output logic [TIME_W-1:0]        out_time,
    output logic signed [PRIO_W-1:0] out_priority,
    output logic [COUNT_W-1:0]       count,
    output logic                     head_valid,
    output logic [TAG_W-1:0]         head_tag,
    output logic [TIME_W-1:0]        head_time
);

    localparam int SLOT_W = $clog2(CAPACITY + 1);
    localparam int ENT_W  = TIME_W + PRIO_W + ORDER_BITS + TAG_W;
    localparam logic [ORDER_BITS-1:0] ORDER_MAX = '1;

    typedef struct packed {
        logic [TIME_W-1:0]        t;
        logic signed [PRIO_W-1:0] p;
        logic [ORDER_BITS-1:0]    o;
        logic [TAG_W-1:0]         g;
    } entry_t;

    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,
        S_MAP   = 16'h0002,
        S_DEC   = 16'h0004,
        S_RDL   = 16'h0008,
        S_PLACE = 16'h0010,
        S_UPRD  = 16'h0020,
        S_UPCMP = 16'h0040,
        S_DNRD1 = 16'h0080,
        S_DNRD2 = 16'h0100,
        S_DNCMP = 16'h0200,
        S_WRA   = 16'h0400,
        S_WRB   = 16'h0800,
        S_HEAD  = 16'h1000,
        S_HEADW = 16'h2000,
        S_DONE  = 16'h4000,
        S_WAITC = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    // command registers
    kind_t                 kind_reg;
    logic [TAG_W-1:0]      tag_reg;
    entry_t                new_reg;
    logic [SLOT_W-1:0]     cnt_reg;
    logic [ORDER_BITS-1:0] ord_reg;
    logic [2:0]            st_reg;
    entry_t                rem_reg;
    logic                  rem_valid_reg;
    entry_t                cur_reg;   // entry being sifted
    logic [SLOT_W-1:0]     pos_reg;
    entry_t                oth_reg;   // parent or chosen child
    logic [SLOT_W-1:0]     oth_pos_reg;
    logic                  down_reg;  // sift down phase; also marks the last slot pending
    entry_t                head_reg;

    // memory ports
    logic              hm_we;
    logic [SLOT_W-1:0] hm_wa, hm_ra;
    entry_t            hm_wd, hm_rd;
    logic              pm_we, pm_clr, pm_busy;
    logic [TAG_W-1:0]  pm_wt, pm_rt;
    logic [SLOT_W-1:0] pm_wp, pm_rp;

    emhq_heap_mem #(.SLOT_W(SLOT_W), .DEPTH(CAPACITY + 1), .ENT_W(ENT_W)) u_mem (
        .clk(clk), .wr_en(hm_we), .wr_addr(hm_wa), .wr_data(hm_wd),
        .rd_addr(hm_ra), .rd_data(hm_rd)
    );

    emhq_posmap #(.POS_W(SLOT_W)) u_map (
        .clk(clk), .rst_n(rst_n), .clear_start(pm_clr), .clearing(pm_busy),
        .wr_en(pm_we), .wr_tag(pm_wt), .wr_pos(pm_wp), .rd_tag(pm_rt), .rd_pos(pm_rp)
    );

    // one comparator, operands picked per state
    entry_t cmp_a, cmp_b;
    logic   a_first;
    emhq_before #(.ORD_W(ORDER_BITS)) u_cmp (
        .a_time(cmp_a.t), .a_prio(cmp_a.p), .a_ord(cmp_a.o),
        .b_time(cmp_b.t), .b_prio(cmp_b.p), .b_ord(cmp_b.o), .a_first(a_first)
    );

    always_comb
    begin
        cmp_a = cur_reg;
        cmp_b = oth_reg;
        if (state_reg == S_DNRD2 || state_reg == S_DNCMP)
        begin
            // choose the right child over the left one when it comes first
            cmp_a = hm_rd;
            cmp_b = oth_reg;
        end
    end

    logic [SLOT_W-1:0] child_l;
    assign child_l = {pos_reg[SLOT_W-2:0], 1'b0};

    // registered next values
    logic [SLOT_W-1:0] cnt_next, pos_next, oth_pos_next;
    logic [ORDER_BITS-1:0] ord_next;
    logic [2:0] st_next;
    entry_t rem_next, cur_next, oth_next, head_next;
    logic rem_valid_next, down_next;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ord_next       = ord_reg;
        st_next        = st_reg;
        rem_next       = rem_reg;
        rem_valid_next = rem_valid_reg;
        cur_next       = cur_reg;
        pos_next       = pos_reg;
        oth_next       = oth_reg;
        oth_pos_next   = oth_pos_reg;
        down_next      = down_reg;
        head_next      = head_reg;
        hm_we = 1'b0; hm_wa = pos_reg; hm_wd = cur_reg; hm_ra = pos_reg;
        pm_we = 1'b0; pm_wt = cur_reg.g; pm_wp = pos_reg; pm_rt = event_tag;
        pm_clr = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                st_next = ST_OK;
                rem_valid_next = 1'b0;
                down_next = 1'b0;
                if (start && !pm_busy)
                    state_next = S_MAP;
            end
            S_MAP:
            begin
                // tag map read in flight; fetch slot 1 for a pop
                pm_rt = tag_reg;
                hm_ra = SLOT_W'(1);
                state_next = S_DEC;
            end
            S_DEC:
            begin
                pm_rt = tag_reg;
                state_next = S_HEAD;
                unique case (kind_reg)
                    KIND_INSERT:
                    begin
                        if (pm_rp != '0)
                            st_next = ST_QUEUED;
                        else if (cnt_reg >= SLOT_W'(CAPACITY))
                            st_next = ST_FULL;
                        else if (ord_reg == ORDER_MAX)
                            st_next = ST_EXHAUSTED;
                        else
                        begin
                            cnt_next = cnt_reg + 1'b1;
                            ord_next = ord_reg + 1'b1;
                            cur_next = new_reg;
                            cur_next.o = ord_reg;
                            pos_next = cnt_reg + 1'b1;
                            state_next = S_PLACE;
                        end
                    end
                    KIND_POP, KIND_REMOVE:
                    begin
                        if (kind_reg == KIND_POP && cnt_reg == '0)
                            st_next = ST_EMPTY;
                        else if (kind_reg == KIND_REMOVE &&
                                 (pm_rp == '0 || pm_rp > cnt_reg))
                            st_next = ST_NOT_QUEUED;
                        else
                        begin
                            pos_next = (kind_reg == KIND_POP) ? SLOT_W'(1) : pm_rp;
                            hm_ra = (kind_reg == KIND_POP) ? SLOT_W'(1) : pm_rp;
                            state_next = S_RDL;
                        end
                    end
                    KIND_CLEAR:
                    begin
                        cnt_next = '0;
                        pm_clr = 1'b1;
                        state_next = S_WAITC;
                    end
                    default: state_next = S_HEAD;
                endcase
            end
            S_RDL:
            begin
                // removed entry arrives; fetch the last slot
                rem_next = hm_rd;
                rem_valid_next = 1'b1;
                pm_we = 1'b1;
                pm_wt = hm_rd.g;
                pm_wp = '0;
                hm_ra = cnt_reg;
                oth_pos_next = cnt_reg;
                cnt_next = cnt_reg - 1'b1;
                state_next = S_UPRD;
                down_next = 1'b1;  // marks "last slot pending"
            end
            S_PLACE:
            begin
                // place the sifting entry at pos and fetch its parent
                hm_we = 1'b1;
                pm_we = 1'b1;
                hm_ra = pos_reg >> 1;
                down_next = 1'b0;
                if (pos_reg == SLOT_W'(1))
                    state_next = S_DNRD1;
                else
                    state_next = S_UPCMP;
            end
            S_UPRD:
            begin
                if (down_reg)
                begin
                    // the last entry arrives
                    down_next = 1'b0;
                    if (oth_pos_reg == pos_reg)
                        state_next = S_HEAD;
                    else
                    begin
                        cur_next = hm_rd;
                        state_next = S_PLACE;
                    end
                end
                else
                    state_next = S_UPCMP;
            end
            S_UPCMP:
            begin
                oth_next = hm_rd;
                state_next = S_WRA;
                oth_pos_next = pos_reg >> 1;
            end
            S_WRA:
            begin
                if (!down_reg && a_first)
                begin
                    // move the parent down, continue one level up
                    hm_we = 1'b1; hm_wd = oth_reg;
                    pm_we = 1'b1; pm_wt = oth_reg.g;
                    pos_next = oth_pos_reg;
                    state_next = S_PLACE;
                end
                else if (down_reg && !a_first)
                begin
                    hm_we = 1'b1; hm_wd = oth_reg;
                    pm_we = 1'b1; pm_wt = oth_reg.g;
                    pos_next = oth_pos_reg;
                    hm_wa = pos_reg;
                    state_next = S_WRB;
                end
                else if (down_reg)
                    state_next = S_HEAD;
                else
                    state_next = S_DNRD1;
            end
            S_WRB:
            begin
                hm_we = 1'b1;
                pm_we = 1'b1;
                state_next = S_DNRD1;
            end
            S_DNRD1:
            begin
                down_next = 1'b1;
                if (child_l > cnt_reg || pos_reg[SLOT_W-1])
                    state_next = S_HEAD;
                else
                begin
                    hm_ra = child_l;
                    state_next = S_DNRD2;
                end
            end
            S_DNRD2:
            begin
                // left child arrives; fetch the right one
                oth_next = hm_rd;
                oth_pos_next = child_l;
                hm_ra = child_l + 1'b1;
                if (child_l < cnt_reg)
                    state_next = S_DNCMP;
                else
                    state_next = S_WRA;
            end
            S_DNCMP:
            begin
                if (a_first)
                begin
                    oth_next = hm_rd;
                    oth_pos_next = child_l + 1'b1;
                end
                state_next = S_WRA;
            end
            S_WAITC:
            begin
                if (!pm_busy)
                    state_next = S_HEAD;
            end
            S_HEAD:
            begin
                hm_ra = SLOT_W'(1);
                state_next = S_HEADW;
            end
            S_HEADW:
            begin
                head_next = hm_rd;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            ord_reg       <= '0;
            rem_valid_reg <= 1'b0;
            down_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ord_reg       <= ord_next;
            rem_valid_reg <= rem_valid_next;
            down_reg      <= down_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start && !pm_busy)
        begin
            kind_reg  <= kind_t'(kind);
            tag_reg   <= event_tag;
            new_reg.t <= arrival_time;
            new_reg.p <= priority_req;
            new_reg.o <= '0;
            new_reg.g <= event_tag;
        end
        st_reg      <= st_next;
        rem_reg     <= rem_next;
        cur_reg     <= cur_next;
        pos_reg     <= pos_next;
        oth_reg     <= oth_next;
        oth_pos_reg <= oth_pos_next;
        head_reg    <= head_next;
    end

    assign busy         = (state_reg != S_IDLE) || pm_busy;
    assign done         = (state_reg == S_DONE);
    assign status       = st_reg;
    assign out_tag      = rem_valid_reg ? rem_reg.g : '0;
    assign out_time     = rem_valid_reg ? rem_reg.t : '0;
    assign out_priority = rem_valid_reg ? rem_reg.p : '0;
    assign count        = COUNT_W'(cnt_reg);
    assign head_valid   = (cnt_reg != '0);
    assign head_tag     = head_valid ? head_reg.g : '0;
    assign head_time    = head_valid ? head_reg.t : '0;

endmodule

/* sim/event_min_heap_queue_top_test.sv */
// ----------------------------------------------------------------------------
// event_min_heap_queue_top_test: testbench of the event min-heap queue
// A directed table followed by random insert, pop, remove and clear
// commands. Each result is predicted by the testbench's own heap or given by its
// directed row, and is checked field by field as it comes out of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module event_min_heap_queue_top_test;
    import emhq_pkg::*;

    localparam int RANDOM_ITEMS = 1300;
    localparam int IDLE_LIMIT   = 20000;
    localparam int DRAIN_CYCLES = 200;
    localparam int CAP          = CAPACITY_D;
    localparam logic [ORDER_D-1:0] ORDER_LAST = '1;

    typedef struct packed {
        logic [2:0]               status;
        logic [TAG_W-1:0]         out_tag;
        logic [TIME_W-1:0]        out_time;
        logic signed [PRIO_W-1:0] out_priority;
        logic [COUNT_W-1:0]       count;
        logic                     head_valid;
        logic [TAG_W-1:0]         head_tag;
        logic [TIME_W-1:0]        head_time;
    } heap_result_t;

    typedef struct {
        kind_t                    kind;
        logic [TAG_W-1:0]         tag;
        logic [TIME_W-1:0]        atime;
        logic signed [PRIO_W-1:0] prio;
        bit                       typed;
        heap_result_t             want;
    } command_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [1:0]               kind = KIND_INSERT;
    logic [TAG_W-1:0]         event_tag = '0;
    logic [TIME_W-1:0]        arrival_time = '0;
    logic signed [PRIO_W-1:0] priority_req = '0;
    logic                     done;
    logic [2:0]               status;
    logic [TAG_W-1:0]         out_tag;
    logic [TIME_W-1:0]        out_time;
    logic signed [PRIO_W-1:0] out_priority;
    logic [COUNT_W-1:0]       count;
    logic                     head_valid;
    logic [TAG_W-1:0]         head_tag;
    logic [TIME_W-1:0]        head_time;

    event_min_heap_queue_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .event_tag    (event_tag),
        .arrival_time (arrival_time),
        .priority_req (priority_req),
        .done         (done),
        .status       (status),
        .out_tag      (out_tag),
        .out_time     (out_time),
        .out_priority (out_priority),
        .count        (count),
        .head_valid   (head_valid),
        .head_tag     (head_tag),
        .head_time    (head_time)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Heap model
    // ------------------------------------------------------------------
    logic [TIME_W-1:0]        hp_time  [1:CAP];
    logic signed [PRIO_W-1:0] hp_prio  [1:CAP];
    logic [ORDER_D-1:0]       hp_order [1:CAP];
    logic [TAG_W-1:0]         hp_tag   [1:CAP];
    int                       tag_slot [TAGS];
    int                       queued_n = 0;
    logic [ORDER_D-1:0]       next_order = '0;

    heap_result_t expected_results[$];
    int           mismatches = 0;
    bit           timed_out = 1'b0;

    function automatic bit served_first(int a, int b);
        if (hp_time[a] != hp_time[b])
            return hp_time[a] < hp_time[b];
        if (hp_prio[a] != hp_prio[b])
            return hp_prio[a] < hp_prio[b];
        return hp_order[a] < hp_order[b];
    endfunction

    function automatic void swap_slots(int a, int b);
        logic [TIME_W-1:0]        t;
        logic signed [PRIO_W-1:0] p;
        logic [ORDER_D-1:0]       o;
        logic [TAG_W-1:0]         g;
        t = hp_time[a];  hp_time[a]  = hp_time[b];  hp_time[b]  = t;
        p = hp_prio[a];  hp_prio[a]  = hp_prio[b];  hp_prio[b]  = p;
        o = hp_order[a]; hp_order[a] = hp_order[b]; hp_order[b] = o;
        g = hp_tag[a];   hp_tag[a]   = hp_tag[b];   hp_tag[b]   = g;
        tag_slot[hp_tag[a]] = a;
        tag_slot[hp_tag[b]] = b;
    endfunction

    function automatic void sift_up(int pos);
        while (pos > 1 && served_first(pos, pos / 2)) begin
            swap_slots(pos, pos / 2);
            pos = pos / 2;
        end
    endfunction

    function automatic void sift_down(int pos);
        int c;
        forever begin
            c = pos * 2;
            if (c > queued_n)
                break;
            if (c < queued_n && served_first(c + 1, c))
                c++;
            if (!served_first(c, pos))
                break;
            swap_slots(pos, c);
            pos = c;
        end
    endfunction

    function automatic void take_slot(int pos);
        int               last;
        logic [TAG_W-1:0] moved;
        last = queued_n;
        tag_slot[hp_tag[pos]] = 0;
        queued_n--;
        if (pos != last) begin
            hp_time[pos]  = hp_time[last];
            hp_prio[pos]  = hp_prio[last];
            hp_order[pos] = hp_order[last];
            hp_tag[pos]   = hp_tag[last];
            moved         = hp_tag[last];
            tag_slot[moved] = pos;
            sift_up(pos);
            sift_down(tag_slot[moved]);
        end
    endfunction

    function automatic heap_result_t heap_apply(kind_t k, logic [TAG_W-1:0] tg,
                                                logic [TIME_W-1:0] tm,
                                                logic signed [PRIO_W-1:0] pr);
        heap_result_t r;
        int           pos;
        r = '0;
        r.status = ST_OK;
        case (k)
            KIND_INSERT: begin
                if (tag_slot[tg] != 0)
                    r.status = ST_QUEUED;
                else if (queued_n >= CAP)
                    r.status = ST_FULL;
                else if (next_order == ORDER_LAST)
                    r.status = ST_EXHAUSTED;
                else begin
                    queued_n++;
                    hp_time[queued_n]  = tm;
                    hp_prio[queued_n]  = pr;
                    hp_order[queued_n] = next_order;
                    hp_tag[queued_n]   = tg;
                    next_order++;
                    tag_slot[tg] = queued_n;
                    sift_up(queued_n);
                end
            end
            KIND_POP, KIND_REMOVE: begin
                if (k == KIND_POP) begin
                    pos = (queued_n != 0) ? 1 : 0;
                    if (pos == 0)
                        r.status = ST_EMPTY;
                end else begin
                    pos = tag_slot[tg];
                    if (pos == 0 || pos > queued_n) begin
                        pos = 0;
                        r.status = ST_NOT_QUEUED;
                    end
                end
                if (pos != 0) begin
                    r.out_tag      = hp_tag[pos];
                    r.out_time     = hp_time[pos];
                    r.out_priority = hp_prio[pos];
                    take_slot(pos);
                end
            end
            default: begin
                queued_n = 0;
                foreach (tag_slot[i])
                    tag_slot[i] = 0;
            end
        endcase
        r.count      = COUNT_W'(queued_n);
        r.head_valid = (queued_n != 0);
        if (queued_n != 0) begin
            r.head_tag  = hp_tag[1];
            r.head_time = hp_time[1];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic field_mismatch(string field, logic [63:0] want, logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h",
                     $realtime, field, want, got);
    endtask

    always @(posedge clk) begin
        heap_result_t w;
        if (rst_n && done) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with no transaction outstanding", $realtime);
            end else begin
                w = expected_results.pop_front();
                if (status !== w.status)
                    field_mismatch("status", w.status, status);
                if (out_tag !== w.out_tag)
                    field_mismatch("out_tag", w.out_tag, out_tag);
                if (out_time !== w.out_time)
                    field_mismatch("out_time", w.out_time, out_time);
                if (out_priority !== w.out_priority)
                    field_mismatch("out_priority", w.out_priority, out_priority);
                if (count !== w.count)
                    field_mismatch("count", w.count, count);
                if (head_valid !== w.head_valid)
                    field_mismatch("head_valid", w.head_valid, head_valid);
                if (head_tag !== w.head_tag)
                    field_mismatch("head_tag", w.head_tag, head_tag);
                if (head_time !== w.head_time)
                    field_mismatch("head_time", w.head_time, head_time);
            end
        end
    end

    // Any cycle that accepts a command or delivers a result resets the watchdog.
    int idle_cycles = 0;
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    command_row_t directed_rows[$];
    int           burst_left = 0;

    task automatic add_row(kind_t k, logic [TAG_W-1:0] tg, logic [TIME_W-1:0] tm,
                           logic signed [PRIO_W-1:0] pr, bit typed = 1'b0,
                           heap_result_t want = '0);
        command_row_t row;
        row.kind  = k;
        row.tag   = tg;
        row.atime = tm;
        row.prio  = pr;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    // Drives one transaction, waits for it to be taken, then maybe idles.
    task automatic issue(kind_t k, logic [TAG_W-1:0] tg, logic [TIME_W-1:0] tm,
                         logic signed [PRIO_W-1:0] pr, bit typed, heap_result_t want);
        heap_result_t predicted;
        int           gap;
        start        <= 1'b1;
        kind         <= k;
        event_tag    <= tg;
        arrival_time <= tm;
        priority_req <= pr;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = heap_apply(k, tg, tm, pr);
        expected_results.push_back(typed ? want : predicted);
        if (burst_left > 0)
            burst_left--;
        else begin
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 12);
            gap = $urandom_range(1, 15);
            start <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
    endtask

    task automatic wait_until_drained();
        start <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    initial begin
        heap_result_t w;
        kind_t        k;
        logic [TAG_W-1:0]         tg;
        logic [TIME_W-1:0]        tm;
        logic signed [PRIO_W-1:0] pr;
        int  roll;
        bit  filling;

        foreach (tag_slot[i])
            tag_slot[i] = 0;

        // Results that follow straight from an empty queue or one known entry.
        w = '0;
        w.status = ST_EMPTY;
        add_row(KIND_POP, 12'd0, '0, '0, 1'b1, w);
        w.status = ST_NOT_QUEUED;
        add_row(KIND_REMOVE, 12'hFFF, '1, '1, 1'b1, w);
        w = '0;
        w.status = ST_OK;
        w.count = COUNT_W'(1);
        w.head_valid = 1'b1;
        w.head_tag = 12'd0;
        w.head_time = '1;
        add_row(KIND_INSERT, 12'd0, '1, -16'sd32768, 1'b1, w);
        w.status = ST_QUEUED;
        add_row(KIND_INSERT, 12'd0, '0, 16'sd32767, 1'b1, w);
        add_row(KIND_INSERT, 12'hFFF, '0, 16'sd32767);
        add_row(KIND_INSERT, 12'd7, '0, -16'sd32768);
        add_row(KIND_INSERT, 12'd8, '0, -16'sd32768);
        add_row(KIND_INSERT, 12'd9, '0, -16'sd1);
        add_row(KIND_INSERT, 12'hAAA, 48'h5555_5555_5555, 16'sh5555);
        add_row(KIND_INSERT, 12'h555, 48'hAAAA_AAAA_AAAA, -16'sh5556);
        add_row(KIND_REMOVE, 12'd9, '0, '0);
        add_row(KIND_REMOVE, 12'd9, '0, '0);
        add_row(KIND_POP, 12'd0, '0, '0);
        add_row(KIND_POP, 12'd0, '0, '0);
        add_row(KIND_REMOVE, 12'd0, '0, '0);
        add_row(KIND_INSERT, 12'd3, 48'd1, 16'sd0);
        add_row(KIND_INSERT, 12'd4, 48'd1, 16'sd0);
        w = '0;
        w.status = ST_OK;
        add_row(KIND_CLEAR, 12'd0, '0, '0, 1'b1, w);
        w.status = ST_EMPTY;
        add_row(KIND_POP, 12'd0, '0, '0, 1'b1, w);
        w.status = ST_NOT_QUEUED;
        add_row(KIND_REMOVE, 12'hAAA, '0, '0, 1'b1, w);
        add_row(KIND_INSERT, 12'd3, 48'd2, 16'sd5);
        add_row(KIND_POP, 12'd0, '0, '0);

        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            issue(directed_rows[i].kind, directed_rows[i].tag, directed_rows[i].atime,
                  directed_rows[i].prio, directed_rows[i].typed, directed_rows[i].want);

        // Hold off until the directed part has fully come back.
        wait_until_drained();

        filling = 1'b1;
        w = '0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 150 == 0)
                filling = ~filling | (queued_n < 20);
            if (n == RANDOM_ITEMS / 2)
                wait_until_drained();
            roll = $urandom_range(0, 99);
            if (roll < 2)
                k = KIND_CLEAR;
            else if (roll < (filling ? 70 : 35))
                k = KIND_INSERT;
            else if (roll < (filling ? 82 : 65))
                k = KIND_POP;
            else
                k = KIND_REMOVE;

            tg = $urandom_range(0, 2) == 0 ? TAG_W'($urandom) : TAG_W'($urandom_range(0, 300));
            if (k == KIND_REMOVE && queued_n != 0 && $urandom_range(0, 4) != 0)
                tg = hp_tag[$urandom_range(1, queued_n)];
            case ($urandom_range(0, 3))
                0:       tm = TIME_W'({$urandom, $urandom});
                1:       tm = $urandom_range(0, 3) == 0 ? '1 : '0;
                default: tm = TIME_W'($urandom_range(0, 15));
            endcase
            case ($urandom_range(0, 3))
                0:       pr = PRIO_W'($urandom);
                1:       pr = $urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000;
                default: pr = PRIO_W'($urandom_range(0, 3)) - 16'sd1;
            endcase
            issue(k, tg, tm, pr, 1'b0, w);
        end

        wait_until_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
